>>> rtl/core/spbt_pkg.sv
// shared types and constants for the symmetric pair bit table
// no dependencies

package spbt_pkg;

    localparam logic [1:0] OP_GET       = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_CLEAR_ALL = 2'd2;

    localparam int         ACTIVE_ROWS_W     = 7;
    localparam logic [6:0] ACTIVE_ROWS_RESET = 7'd64;
    localparam int         PAIR_INDEX_W      = 6;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [PAIR_INDEX_W-1:0] row_index;
        logic [PAIR_INDEX_W-1:0] col_index;
        logic                    write_value;
    } in_item_t;

    typedef struct packed {
        logic pair_bit;
        logic range_error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SWEEP,
        ST_LIST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch_item;
        logic sweep_step;
        logic bit_read;
        logic bit_write;
        logic capture_bit;
        logic list_start;
        logic list_step;
        logic list_reset;
        logic load_result;
    } ctl_cmd_t;

    typedef struct packed {
        logic get_ok;
        logic write_ok;
        logic clear_all;
        logic list_ovf;
        logic list_empty;
        logic list_last;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/spbt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module spbt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/spbt_ctrl.sv
// controller state machine for the symmetric pair bit table
// depends on spbt_pkg

module spbt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spbt_pkg::dp_status_t status,
    output spbt_pkg::ctl_cmd_t   cmd
);

    import spbt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (status.get_ok)
                begin
                    state_next = ST_READ;
                end
                else if (status.clear_all && status.list_ovf)
                begin
                    state_next = ST_SWEEP;
                end
                else if (status.clear_all && !status.list_empty)
                begin
                    state_next = ST_LIST;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LIST:
            begin
                if (status.list_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.latch_item = in_valid;
            end
            ST_EXEC:
            begin
                cmd.bit_read  = status.get_ok;
                cmd.bit_write = status.write_ok;
                if (status.clear_all)
                begin
                    cmd.list_start = !status.list_ovf && !status.list_empty;
                    cmd.list_reset = !status.list_ovf && status.list_empty;
                end
            end
            ST_READ:
            begin
                cmd.capture_bit = 1'b1;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                cmd.list_reset = status.sweep_last;
            end
            ST_LIST:
            begin
                cmd.list_step  = 1'b1;
                cmd.list_reset = status.list_last;
            end
            ST_DONE:
            begin
                cmd.load_result = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/spbt_datapath.sv
// datapath: item register, pair index math, bit store, set list, result register
// depends on spbt_pkg and spbt_ram

module spbt_datapath #(
    parameter int MAX_ROWS   = 64,
    parameter int LIST_DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [spbt_pkg::ACTIVE_ROWS_W-1:0]     cfg_wr_data,
    input  spbt_pkg::in_item_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output spbt_pkg::out_item_t                    out_data,
    input  spbt_pkg::ctl_cmd_t                     cmd,
    output spbt_pkg::dp_status_t                   status
);

    import spbt_pkg::*;

    localparam int STORE_BITS = MAX_ROWS * (MAX_ROWS + 1) / 2;
    localparam int STORE_AW   = $clog2(STORE_BITS);
    localparam int LIST_AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int LIM_W      = ($clog2(MAX_ROWS + 1) > ACTIVE_ROWS_W) ?
                                $clog2(MAX_ROWS + 1) : ACTIVE_ROWS_W;
    localparam int TRI_W      = 2 * PAIR_INDEX_W + 1;
    localparam int FULL_W     = (STORE_AW > TRI_W) ? STORE_AW : TRI_W;

    logic [ACTIVE_ROWS_W-1:0] active_rows_reg, active_rows_next;
    in_item_t                 item_reg, item_next;
    logic                     bit_reg, bit_next;
    logic [STORE_AW-1:0]      sweep_reg, sweep_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_reg, out_next;

    logic [LIM_W-1:0]        lim;
    logic                    range_err;
    logic                    is_get, is_write, is_clear;
    logic [PAIR_INDEX_W-1:0] hi, lo;
    logic [TRI_W-1:0]        tri_prod;
    logic [FULL_W-1:0]       idx_full;
    logic [STORE_AW-1:0]     idx;
    logic [CNT_W-1:0]        ptr_inc;
    logic                    list_full;
    logic                    sweep_last;

    logic                bit_we, bit_wdata, bit_rdata;
    logic [STORE_AW-1:0] bit_waddr;
    logic                list_we, list_re;
    logic [LIST_AW-1:0]  list_raddr;
    logic [STORE_AW-1:0] list_rdata;

    // operand decode and pair index
    always_comb
    begin
        lim = (LIM_W'(active_rows_reg) > LIM_W'(MAX_ROWS)) ?
              LIM_W'(MAX_ROWS) : LIM_W'(active_rows_reg);
        range_err = (LIM_W'(item_reg.row_index) >= lim) ||
                    (LIM_W'(item_reg.col_index) >= lim);
        is_get   = item_reg.opcode == OP_GET;
        is_write = item_reg.opcode == OP_WRITE;
        is_clear = item_reg.opcode == OP_CLEAR_ALL;
        if (item_reg.row_index >= item_reg.col_index)
        begin
            hi = item_reg.row_index;
            lo = item_reg.col_index;
        end
        else
        begin
            hi = item_reg.col_index;
            lo = item_reg.row_index;
        end
        tri_prod = TRI_W'(hi) * (TRI_W'(hi) + TRI_W'(1));
        idx_full = FULL_W'(tri_prod >> 1) + FULL_W'(lo);
        idx      = idx_full[STORE_AW-1:0];
    end

    assign ptr_inc    = ptr_reg + CNT_W'(1);
    assign list_full  = cnt_reg == CNT_W'(LIST_DEPTH);
    assign sweep_last = sweep_reg == STORE_AW'(STORE_BITS - 1);

    // bit store port muxing
    always_comb
    begin
        bit_we    = cmd.sweep_step || cmd.bit_write || cmd.list_step;
        bit_wdata = cmd.bit_write ? item_reg.write_value : 1'b0;
        priority if (cmd.sweep_step)
        begin
            bit_waddr = sweep_reg;
        end
        else if (cmd.list_step)
        begin
            bit_waddr = list_rdata;
        end
        else
        begin
            bit_waddr = idx;
        end
    end

    assign list_we    = cmd.bit_write && item_reg.write_value && !list_full;
    assign list_re    = cmd.list_start || cmd.list_step;
    assign list_raddr = cmd.list_start ? '0 : ptr_inc[LIST_AW-1:0];

    spbt_ram #(
        .WIDTH (1),
        .DEPTH (STORE_BITS),
        .AW    (STORE_AW)
    ) u_bit_ram (
        .clk   (clk),
        .we    (bit_we),
        .waddr (bit_waddr),
        .wdata (bit_wdata),
        .re    (cmd.bit_read),
        .raddr (idx),
        .rdata (bit_rdata)
    );

    spbt_ram #(
        .WIDTH (STORE_AW),
        .DEPTH (LIST_DEPTH),
        .AW    (LIST_AW)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (cnt_reg[LIST_AW-1:0]),
        .wdata (idx),
        .re    (list_re),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    // next state of the datapath registers
    always_comb
    begin
        active_rows_next = cfg_wr_en ? cfg_wr_data : active_rows_reg;
        item_next        = cmd.latch_item ? in_data : item_reg;

        bit_next = bit_reg;
        if (cmd.latch_item)
        begin
            bit_next = 1'b0;
        end
        else if (cmd.capture_bit)
        begin
            bit_next = bit_rdata;
        end

        sweep_next = sweep_reg;
        if (cmd.sweep_step)
        begin
            sweep_next = sweep_last ? '0 : sweep_reg + STORE_AW'(1);
        end

        ptr_next = ptr_reg;
        if (cmd.list_start)
        begin
            ptr_next = '0;
        end
        else if (cmd.list_step)
        begin
            ptr_next = ptr_inc;
        end

        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (cmd.list_reset)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.bit_write && item_reg.write_value)
        begin
            if (list_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (cmd.load_result)
        begin
            out_valid_next       = 1'b1;
            out_next.pair_bit    = is_get && !range_err && bit_reg;
            out_next.range_error = (is_get || is_write) && range_err;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_rows_reg <= ACTIVE_ROWS_RESET;
            sweep_reg       <= '0;
            ptr_reg         <= '0;
            cnt_reg         <= '0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_rows_reg <= active_rows_next;
            sweep_reg       <= sweep_next;
            ptr_reg         <= ptr_next;
            cnt_reg         <= cnt_next;
            ovf_reg         <= ovf_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        bit_reg  <= bit_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        status.get_ok     = is_get && !range_err;
        status.write_ok   = is_write && !range_err;
        status.clear_all  = is_clear;
        status.list_ovf   = ovf_reg;
        status.list_empty = cnt_reg == '0;
        status.list_last  = ptr_inc >= cnt_reg;
        status.sweep_last = sweep_last;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LIST_DEPTH))
        else $error("set list count above depth");

    a_ovf_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> list_full)
        else $error("overflow flag with list not full");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bit_write |-> !range_err && is_write)
        else $error("bit store written for an out of range pair");

    a_list_reset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_reset |=> cnt_reg == '0 && !ovf_reg)
        else $error("set list not emptied after clear-all");

endmodule

>>> rtl/core/symmetric_pair_bit_table.sv
// symmetric pair bit table: one bit per unordered (row, col) pair
// top level; depends on spbt_pkg, spbt_ctrl and spbt_datapath
//
// usage:
//   in channel (in_valid/in_ready, in_data) carries get, write or clear-all
//   transactions; out channel (out_valid/out_ready, out_data) returns exactly
//   one result transaction per input transaction, in order.
//   cfg_wr_en/cfg_wr_data write active_rows at once; write it only when idle.
// steps from input acceptance to out_valid:
//   get: decode, registered bit store read, bit capture, result load;
//   write: decode with the bit write, result load; clear-all: a walk of the set
//   list, or a sweep of the whole bit store if the list overflowed, then result load.
// order: one transaction at a time; the result load waits for a free output register;
//   the next is taken the cycle after the previous result enters the output register
// reset: a clearing pass zeroes the bit store, one bit per cycle, over all
//   MAX_ROWS*(MAX_ROWS+1)/2 bits (2080 by default), with in_ready low.
// stall: a held result stays in the output register while the next
//   transaction is accepted and worked on; its result waits until the
//   register is taken.

module symmetric_pair_bit_table #(
    parameter int MAX_ROWS   = 64,
    parameter int LIST_DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [spbt_pkg::ACTIVE_ROWS_W-1:0] cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  spbt_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output spbt_pkg::out_item_t                out_data
);

    import spbt_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    spbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    spbt_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
